FILE: src/ifup_pkg.sv
// shared constants, types and helper functions of the integer factor upscaler
package ifup_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_PLANES  = 3;
    localparam int PIXEL_BITS  = 16;
    localparam int MAX_FACTOR  = 16;

    localparam int COORD_BITS  = 12;
    localparam int DIM_BITS    = 9;
    localparam int PLANE_BITS  = 2;
    localparam int FACTOR_BITS = 5;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 9;
    localparam int IN_TDATA_BITS  = 48;
    localparam int OUT_TDATA_BITS = 16;

    localparam int X_BITS      = $clog2(MAX_WIDTH);
    localparam int Y_BITS      = $clog2(MAX_HEIGHT);
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_PLANES;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int FRAC_BITS   = $clog2(MAX_FACTOR);
    localparam int WEIGHT_BITS = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int LIMIT_BITS  = $clog2(MAX_WIDTH * MAX_FACTOR + 1);

    // reciprocal of the factor, scaled by 2^RECIP_SHIFT and rounded up
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int ACC_BITS    = PIXEL_BITS + WEIGHT_BITS;
    localparam int MUL_BITS    = ACC_BITS + RECIP_BITS;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam int RESET_FACTOR = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANES   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FACTOR   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BILINEAR = 3'd4;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [DIM_BITS-1:0]    width;
        logic [DIM_BITS-1:0]    height;
        logic [PLANE_BITS-1:0]  planes;
        logic [FACTOR_BITS-1:0] factor;
        logic [WEIGHT_BITS-1:0] ff;
        logic [RECIP_BITS-1:0]  recip;
        logic [LIMIT_BITS-1:0]  wf;
        logic [LIMIT_BITS-1:0]  hf;
        logic                   bilinear;
    } cfg_t;

    typedef struct packed {
        logic                   is_query;
        logic                   write_ok;
        logic                   in_range;
        logic                   bilinear;
        logic                   has_r;
        logic                   has_d;
        logic [X_BITS-1:0]      x;
        logic [Y_BITS-1:0]      y;
        logic [PLANE_BITS-1:0]  plane;
        logic [FRAC_BITS-1:0]   fx;
        logic [FRAC_BITS-1:0]   fy;
        logic [PIXEL_BITS-1:0]  sample;
    } cmd_t;

    function automatic logic [RECIP_BITS-1:0] recip_of(input logic [FACTOR_BITS-1:0] f);
        logic [RECIP_BITS-1:0] r;
        unique case (f)
            5'd2:    r = 30'd268435456;
            5'd3:    r = 30'd178956971;
            5'd4:    r = 30'd134217728;
            5'd5:    r = 30'd107374183;
            5'd6:    r = 30'd89478486;
            5'd7:    r = 30'd76695845;
            5'd8:    r = 30'd67108864;
            5'd9:    r = 30'd59652324;
            5'd10:   r = 30'd53687092;
            5'd11:   r = 30'd48806447;
            5'd12:   r = 30'd44739243;
            5'd13:   r = 30'd41297763;
            5'd14:   r = 30'd38347923;
            5'd15:   r = 30'd35791395;
            5'd16:   r = 30'd33554432;
            default: r = 30'd536870912;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_BITS-1:0] addr_of(input logic [X_BITS-1:0] x,
                                                     input logic [Y_BITS-1:0] y,
                                                     input logic [PLANE_BITS-1:0] p);
        return ADDR_BITS'((int'(p) * MAX_HEIGHT + int'(y)) * MAX_WIDTH + int'(x));
    endfunction

endpackage

FILE: src/ifup_front.sv
// front end: accepts items, splits query coordinates by the factor and builds commands
module ifup_front import ifup_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_kind,
    input  logic [COORD_BITS-1:0]  in_cx,
    input  logic [COORD_BITS-1:0]  in_cy,
    input  logic [PLANE_BITS-1:0]  in_plane,
    input  logic [PIXEL_BITS-1:0]  in_sample,
    output logic                   push,
    output cmd_t                   push_cmd,
    input  logic                   queue_full
);

    logic                   s1_valid_reg;
    logic                   s1_kind_reg;
    logic [COORD_BITS-1:0]  s1_cx_reg;
    logic [COORD_BITS-1:0]  s1_cy_reg;
    logic [PLANE_BITS-1:0]  s1_plane_reg;
    logic [PIXEL_BITS-1:0]  s1_sample_reg;
    logic [COORD_BITS-1:0]  s1_qx_reg;
    logic [COORD_BITS-1:0]  s1_qy_reg;
    logic                   s1_inr_reg;
    logic                   s1_ldok_reg;

    logic                   accept;
    logic [COORD_BITS+RECIP_BITS-1:0]  px;
    logic [COORD_BITS+RECIP_BITS-1:0]  py;
    logic                   inr;
    logic                   ldok;
    logic [COORD_BITS+FACTOR_BITS-1:0] bx;
    logic [COORD_BITS+FACTOR_BITS-1:0] by;
    logic [COORD_BITS-1:0]  rem_x;
    logic [COORD_BITS-1:0]  rem_y;
    logic [DIM_BITS-1:0]    nx;
    logic [DIM_BITS-1:0]    ny;
    logic                   is_query;

    assign push     = s1_valid_reg && !queue_full;
    assign in_ready = !s1_valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;

    // quotient by the factor through its reciprocal
    assign px = in_cx * cfg.recip;
    assign py = in_cy * cfg.recip;

    assign inr  = (LIMIT_BITS'(in_cx) < cfg.wf) && (LIMIT_BITS'(in_cy) < cfg.hf)
               && (in_plane < cfg.planes);
    assign ldok = (in_cx < COORD_BITS'(cfg.width)) && (in_cy < COORD_BITS'(cfg.height))
               && (in_plane < cfg.planes);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= in_kind;
            s1_cx_reg     <= in_cx;
            s1_cy_reg     <= in_cy;
            s1_plane_reg  <= in_plane;
            s1_sample_reg <= in_sample;
            s1_qx_reg     <= px[RECIP_SHIFT +: COORD_BITS];
            s1_qy_reg     <= py[RECIP_SHIFT +: COORD_BITS];
            s1_inr_reg    <= inr;
            s1_ldok_reg   <= ldok;
        end
    end

    // remainder and edge flags
    assign bx    = s1_qx_reg * cfg.factor;
    assign by    = s1_qy_reg * cfg.factor;
    assign rem_x = s1_cx_reg - bx[COORD_BITS-1:0];
    assign rem_y = s1_cy_reg - by[COORD_BITS-1:0];
    assign nx    = DIM_BITS'(s1_qx_reg[X_BITS-1:0]) + DIM_BITS'(1);
    assign ny    = DIM_BITS'(s1_qy_reg[Y_BITS-1:0]) + DIM_BITS'(1);
    assign is_query = (s1_kind_reg == KIND_QUERY);

    always_comb
    begin
        push_cmd.is_query = is_query;
        push_cmd.write_ok = s1_ldok_reg;
        push_cmd.in_range = s1_inr_reg;
        push_cmd.bilinear = cfg.bilinear;
        push_cmd.has_r    = is_query && (nx < cfg.width);
        push_cmd.has_d    = is_query && (ny < cfg.height);
        push_cmd.x        = is_query ? s1_qx_reg[X_BITS-1:0] : s1_cx_reg[X_BITS-1:0];
        push_cmd.y        = is_query ? s1_qy_reg[Y_BITS-1:0] : s1_cy_reg[Y_BITS-1:0];
        push_cmd.plane    = s1_plane_reg;
        push_cmd.fx       = rem_x[FRAC_BITS-1:0];
        push_cmd.fy       = rem_y[FRAC_BITS-1:0];
        push_cmd.sample   = s1_sample_reg;
    end

endmodule

FILE: src/ifup_queue.sv
// command queue between the front end and the frame engine
module ifup_queue import ifup_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    cmd_t                      slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;

    assign full      = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QUEUE_PTR_BITS+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QUEUE_PTR_BITS+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/ifup_back.sv
// frame engine: frame memory, neighbor read sequencer and weighting pipeline
module ifup_back import ifup_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  q_valid,
    input  cmd_t                  q_cmd,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIXEL_BITS-1:0] out_sample,
    output logic                  out_in_range
);

    logic [PIXEL_BITS-1:0] mem [STORE_DEPTH];

    logic                   adv;
    cmd_t                   cmd_reg;
    logic                   cmd_valid_reg;
    logic [1:0]             k_reg;
    logic [1:0]             last_k;
    logic                   slot_done;
    logic                   is_q;
    logic                   mem_we;
    logic                   mem_re;
    logic                   x_inc;
    logic                   y_inc;
    logic [X_BITS-1:0]      xa;
    logic [Y_BITS-1:0]      ya;
    logic [ADDR_BITS-1:0]   addr;
    logic [FACTOR_BITS-1:0] frx;
    logic [FACTOR_BITS-1:0] fry;
    logic [FACTOR_BITS-1:0] mx;
    logic [FACTOR_BITS-1:0] my;
    logic [2*FACTOR_BITS-1:0] wprod;
    logic [WEIGHT_BITS-1:0] weight;

    logic [PIXEL_BITS-1:0]  rd_data_reg;
    logic                   t1_valid_reg;
    logic                   t1_first_reg;
    logic                   t1_last_reg;
    logic                   t1_zero_reg;
    logic                   t1_inr_reg;
    logic [WEIGHT_BITS-1:0] t1_w_reg;
    logic                   t2_valid_reg;
    logic                   t2_first_reg;
    logic                   t2_last_reg;
    logic                   t2_inr_reg;
    logic [ACC_BITS-1:0]    prod_reg;
    logic                   t3_valid_reg;
    logic                   t3_inr_reg;
    logic [ACC_BITS-1:0]    acc_reg;
    logic                   t4_valid_reg;
    logic                   t4_inr_reg;
    logic [MUL_BITS-1:0]    m1_reg;
    logic                   t5_valid_reg;
    logic                   t5_inr_reg;
    logic [MUL_BITS-1:0]    m2_reg;
    logic                   out_valid_reg;
    logic                   out_inr_reg;
    logic [PIXEL_BITS-1:0]  out_sample_reg;

    assign adv = !out_valid_reg || out_ready;

    // read sequencer
    assign last_k    = (cmd_reg.is_query && cmd_reg.in_range && cmd_reg.bilinear) ? 2'd3 : 2'd0;
    assign slot_done = cmd_valid_reg && (k_reg == last_k);
    assign pop       = adv && q_valid && (!cmd_valid_reg || slot_done);
    assign is_q      = cmd_valid_reg && cmd_reg.is_query;
    assign mem_we    = adv && cmd_valid_reg && !cmd_reg.is_query && cmd_reg.write_ok;
    assign mem_re    = adv && is_q && cmd_reg.in_range;

    // missing neighbors fall back to the base pixel
    assign x_inc = k_reg[0] && cmd_reg.has_r && (!k_reg[1] || cmd_reg.has_d);
    assign y_inc = k_reg[1] && cmd_reg.has_d && (!k_reg[0] || cmd_reg.has_r);
    assign xa    = cmd_reg.x + X_BITS'(x_inc);
    assign ya    = cmd_reg.y + Y_BITS'(y_inc);
    assign addr  = addr_of(xa, ya, cmd_reg.plane);

    assign frx    = cfg.factor - FACTOR_BITS'(cmd_reg.fx);
    assign fry    = cfg.factor - FACTOR_BITS'(cmd_reg.fy);
    assign mx     = k_reg[0] ? FACTOR_BITS'(cmd_reg.fx) : frx;
    assign my     = k_reg[1] ? FACTOR_BITS'(cmd_reg.fy) : fry;
    assign wprod  = mx * my;
    assign weight = cmd_reg.bilinear ? wprod[WEIGHT_BITS-1:0] : cfg.ff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            k_reg         <= 2'd0;
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            t3_valid_reg  <= 1'b0;
            t4_valid_reg  <= 1'b0;
            t5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (pop)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (slot_done)
            begin
                cmd_valid_reg <= 1'b0;
            end
            if (pop || slot_done)
            begin
                k_reg <= 2'd0;
            end
            else if (cmd_valid_reg)
            begin
                k_reg <= k_reg + 2'd1;
            end
            t1_valid_reg  <= is_q;
            t2_valid_reg  <= t1_valid_reg;
            t3_valid_reg  <= t2_valid_reg && t2_last_reg;
            t4_valid_reg  <= t3_valid_reg;
            t5_valid_reg  <= t4_valid_reg;
            out_valid_reg <= t5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_cmd;
        end
    end

    // frame memory, one access per cycle unless the output stalls
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= cmd_reg.sample;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // weighting, accumulation and division by the squared factor
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_first_reg <= (k_reg == 2'd0);
            t1_last_reg  <= slot_done;
            t1_zero_reg  <= !cmd_reg.in_range;
            t1_inr_reg   <= cmd_reg.in_range;
            t1_w_reg     <= weight;

            prod_reg     <= t1_zero_reg ? '0 : ACC_BITS'(rd_data_reg * t1_w_reg);
            t2_first_reg <= t1_first_reg;
            t2_last_reg  <= t1_last_reg;
            t2_inr_reg   <= t1_inr_reg;

            if (t2_valid_reg)
            begin
                acc_reg <= (t2_first_reg ? ACC_BITS'(cfg.ff >> 1) : acc_reg) + prod_reg;
            end
            t3_inr_reg <= t2_inr_reg;

            m1_reg     <= acc_reg * cfg.recip;
            t4_inr_reg <= t3_inr_reg;

            m2_reg     <= m1_reg[RECIP_SHIFT +: ACC_BITS] * cfg.recip;
            t5_inr_reg <= t4_inr_reg;

            out_sample_reg <= m2_reg[RECIP_SHIFT +: PIXEL_BITS];
            out_inr_reg    <= t5_inr_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_sample   = out_sample_reg;
    assign out_in_range = out_inr_reg;

endmodule

FILE: src/integer_factor_image_upscaler.sv
// top level of the integer factor image upscaler
//
// input stream: s_axis_tuser is the item kind (load or query); s_axis_tdata
// carries the coordinates, plane and source sample. A load writes its sample
// into the frame memory only if in range and gives no result; a query gives
// exactly one result on the master stream, sample in m_axis_tdata and the
// in-range flag in m_axis_tuser. Results leave in the order the queries were
// accepted. The frame memory has one port, so an in-range bilinear query
// makes one read per neighbor, one after another, while a load or nearest
// query needs a single access. A four-entry command queue lets the front end
// keep accepting while the engine is busy. Reset restores the default
// configuration; frame memory contents are undefined until loaded, with no
// clearing pass. When the receiver stalls, the result holds in the output
// register, the engine freezes and the input side keeps accepting until the
// queue and the front register are full. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while idle, which
// the block itself does not enforce.
module integer_factor_image_upscaler import ifup_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // coord_x, coord_y, plane, sample_in, zero pad
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // kind
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // sample_out
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    // in_range
    output logic                      m_axis_tuser,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t                   cfg_reg;
    logic [DIM_BITS-1:0]    dim_sat_w;
    logic [DIM_BITS-1:0]    dim_sat_h;
    logic [PLANE_BITS-1:0]  planes_sat;
    logic [FACTOR_BITS-1:0] factor_sat;
    logic [2*FACTOR_BITS-1:0] ff_new;

    logic [COORD_BITS-1:0]  in_cx;
    logic [COORD_BITS-1:0]  in_cy;
    logic [PLANE_BITS-1:0]  in_plane;
    logic [PIXEL_BITS-1:0]  in_sample;

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;
    logic [PIXEL_BITS-1:0] out_sample;

    assign in_cx     = s_axis_tdata[COORD_BITS-1:0];
    assign in_cy     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_plane  = s_axis_tdata[2*COORD_BITS +: PLANE_BITS];
    assign in_sample = s_axis_tdata[2*COORD_BITS+PLANE_BITS +: PIXEL_BITS];

    // saturate register writes into their legal ranges (planes and factor from low bits)
    always_comb
    begin
        dim_sat_w = cfg_data;
        if (cfg_data == '0)
        begin
            dim_sat_w = DIM_BITS'(1);
        end
        else if (int'(cfg_data) > MAX_WIDTH)
        begin
            dim_sat_w = DIM_BITS'(MAX_WIDTH);
        end
        dim_sat_h = cfg_data;
        if (cfg_data == '0)
        begin
            dim_sat_h = DIM_BITS'(1);
        end
        else if (int'(cfg_data) > MAX_HEIGHT)
        begin
            dim_sat_h = DIM_BITS'(MAX_HEIGHT);
        end
        planes_sat = cfg_data[PLANE_BITS-1:0];
        if (cfg_data[PLANE_BITS-1:0] == '0)
        begin
            planes_sat = PLANE_BITS'(1);
        end
        else if (int'(cfg_data[PLANE_BITS-1:0]) > MAX_PLANES)
        begin
            planes_sat = PLANE_BITS'(MAX_PLANES);
        end
        factor_sat = cfg_data[FACTOR_BITS-1:0];
        if (cfg_data[FACTOR_BITS-1:0] == '0)
        begin
            factor_sat = FACTOR_BITS'(1);
        end
        else if (int'(cfg_data[FACTOR_BITS-1:0]) > MAX_FACTOR)
        begin
            factor_sat = FACTOR_BITS'(MAX_FACTOR);
        end
    end

    assign ff_new = factor_sat * factor_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width    <= DIM_BITS'(MAX_WIDTH);
            cfg_reg.height   <= DIM_BITS'(MAX_HEIGHT);
            cfg_reg.planes   <= PLANE_BITS'(1);
            cfg_reg.factor   <= FACTOR_BITS'(RESET_FACTOR);
            cfg_reg.ff       <= WEIGHT_BITS'(RESET_FACTOR * RESET_FACTOR);
            cfg_reg.recip    <= recip_of(FACTOR_BITS'(RESET_FACTOR));
            cfg_reg.wf       <= LIMIT_BITS'(MAX_WIDTH * RESET_FACTOR);
            cfg_reg.hf       <= LIMIT_BITS'(MAX_HEIGHT * RESET_FACTOR);
            cfg_reg.bilinear <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:
                begin
                    cfg_reg.width <= dim_sat_w;
                    cfg_reg.wf    <= LIMIT_BITS'(dim_sat_w * cfg_reg.factor);
                end
                CFG_HEIGHT:
                begin
                    cfg_reg.height <= dim_sat_h;
                    cfg_reg.hf     <= LIMIT_BITS'(dim_sat_h * cfg_reg.factor);
                end
                CFG_PLANES:
                begin
                    cfg_reg.planes <= planes_sat;
                end
                CFG_FACTOR:
                begin
                    cfg_reg.factor <= factor_sat;
                    cfg_reg.ff     <= ff_new[WEIGHT_BITS-1:0];
                    cfg_reg.recip  <= recip_of(factor_sat);
                    cfg_reg.wf     <= LIMIT_BITS'(cfg_reg.width * factor_sat);
                    cfg_reg.hf     <= LIMIT_BITS'(cfg_reg.height * factor_sat);
                end
                CFG_BILINEAR:
                begin
                    cfg_reg.bilinear <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    ifup_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_cx      (in_cx),
        .in_cy      (in_cy),
        .in_plane   (in_plane),
        .in_sample  (in_sample),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    ifup_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_cmd   (q_cmd)
    );

    ifup_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_sample   (out_sample),
        .out_in_range (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'(out_sample);

endmodule
